// File: src/sst_pkg.sv
// ---------------------------------------------------------------------------
// Servo slew tracker package
// Shared widths, reset values, register indexes and divider constants.
// ---------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int ANGLE_W    = 11;  // servo angles, tenths of a degree
  localparam int SOUND_W    = 12;  // signed sound direction
  localparam int INTERVAL_W = 16;  // min_interval register
  localparam int IDX_W      = 3;   // configuration register index
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 16;  // sound_angle padded to whole bytes
  localparam int M_TDATA_W  = 16;  // servo_angle and reached padded

  localparam int TICK_COUNT_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CENTER       = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEFT_LIMIT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RIGHT_LIMIT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEADBAND     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_STEP     = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = 3'd5;

  // Reset values
  localparam logic [ANGLE_W-1:0]    CENTER_RST       = 11'd900;
  localparam logic [ANGLE_W-1:0]    LEFT_LIMIT_RST   = 11'd0;
  localparam logic [ANGLE_W-1:0]    RIGHT_LIMIT_RST  = 11'd1800;
  localparam logic [ANGLE_W-1:0]    DEADBAND_RST     = 11'd20;
  localparam logic [ANGLE_W-1:0]    MAX_STEP_RST     = 11'd30;
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd21;
  localparam logic [ANGLE_W-1:0]    CURRENT_RST      = 11'd900;

  // Direction clamp, plus or minus ninety degrees
  localparam logic signed [SOUND_W-1:0] DIR_MAX = 12'sd900;
  localparam logic signed [SOUND_W-1:0] DIR_MIN = -12'sd900;

  // Rounded division by 900: q = floor((mag + 450) / 900)
  //   = floor(((mag + 450) >> 2) / 225) = (y * RECIP_K) >> RECIP_SHIFT,
  // exact for y below 2^19.
  localparam int                PROD_W      = 22;  // |a * span| <= 1842300
  localparam int                MAG_W       = 21;
  localparam logic [MAG_W-1:0]  ROUND_HALF  = 21'd450;
  localparam int                Y_W         = 19;
  localparam int                RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_K    = 20'd596524;
  localparam int                RECIP_SHIFT = 27;

endpackage

`default_nettype wire

// File: src/servo_slew_tracker_unit.sv
// ---------------------------------------------------------------------------
// Servo slew tracker
// Maps sound directions to a servo target and issues slew-limited commands.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports            | Beat contents (lowest bit first)
//  ---------+------------------+----------------------------------------------
//  in       | s_axis_*         | tuser: mode; tdata: sound_angle[11:0], pad
//  out      | m_axis_*         | tdata: servo_angle[10:0], reached, pad
//  config   | cfg_*            | cfg_index selects register, cfg_data value
//
// An input beat is accepted every cycle while the pipeline can move. A beat
// passes four register stages: clamp and multiply by the span, rounded
// division by 900 through a reciprocal multiply, offset from the centre with
// the limit clamp, then the state update, which loads the output register.
// The result register is loaded by the state update after the beat has passed
// the stage 1, stage 2 and stage 3 registers in that order; the two
// multipliers set the stage split. Each stage holds only while its successor
// is full, so bubbles are squeezed out when the output side stalls, and the
// input side stops only once every stage is occupied. Synchronous reset
// clears the pipeline, the tracking state and the configuration registers to
// their reset values; configuration writes are always taken (cfg_ready is
// high).
//
`default_nettype none

module servo_slew_tracker_unit #(
  parameter int TICK_COUNT_BITS = sst_pkg::TICK_COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sst_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [11:0] sound_angle
  input  wire logic                            s_axis_tuser,  // [0] mode
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [sst_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [10:0] servo_angle,
                                                              // [11] reached
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sst_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW    = sst_pkg::ANGLE_W;
  localparam int CMP_W = (TICK_COUNT_BITS > sst_pkg::INTERVAL_W) ?
                         TICK_COUNT_BITS : sst_pkg::INTERVAL_W;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [AW-1:0]                   center_angle;
  logic [AW-1:0]                   left_limit;
  logic [AW-1:0]                   right_limit;
  logic [AW-1:0]                   deadband;
  logic [AW-1:0]                   max_step;
  logic [sst_pkg::INTERVAL_W-1:0]  min_interval;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_angle <= sst_pkg::CENTER_RST;
      left_limit   <= sst_pkg::LEFT_LIMIT_RST;
      right_limit  <= sst_pkg::RIGHT_LIMIT_RST;
      deadband     <= sst_pkg::DEADBAND_RST;
      max_step     <= sst_pkg::MAX_STEP_RST;
      min_interval <= sst_pkg::MIN_INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sst_pkg::REG_CENTER:       center_angle <= cfg_data[AW-1:0];
        sst_pkg::REG_LEFT_LIMIT:   left_limit   <= cfg_data[AW-1:0];
        sst_pkg::REG_RIGHT_LIMIT:  right_limit  <= cfg_data[AW-1:0];
        sst_pkg::REG_DEADBAND:     deadband     <= cfg_data[AW-1:0];
        sst_pkg::REG_MAX_STEP:     max_step     <= cfg_data[AW-1:0];
        sst_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data[sst_pkg::INTERVAL_W-1:0];
        default: ;  // indexes beyond the register list are ignored
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline flow control: a stage may load when it is empty or when its
  // contents move on in the same cycle. The beat in stage 3 is consumed by
  // the state update, which needs room in the output register.
  // -------------------------------------------------------------------------
  logic v1, v2, v3;
  logic out_slot, rdy1, rdy2, rdy3, go4;

  assign out_slot      = !m_axis_tvalid || m_axis_tready;
  assign go4           = v3 && out_slot;
  assign rdy3          = !v3 || out_slot;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: clamp the direction to plus or minus ninety degrees and multiply
  // by the span on its side of the centre.
  // -------------------------------------------------------------------------
  logic signed [sst_pkg::SOUND_W-1:0]  raw_angle;
  logic signed [AW-1:0]                dir_clamped;
  logic signed [AW:0]                  span;
  logic signed [AW+AW:0]               num_full;

  assign raw_angle = signed'(s_axis_tdata[sst_pkg::SOUND_W-1:0]);

  always_comb begin
    if (raw_angle < sst_pkg::DIR_MIN) begin
      dir_clamped = sst_pkg::DIR_MIN[AW-1:0];
    end else if (raw_angle > sst_pkg::DIR_MAX) begin
      dir_clamped = sst_pkg::DIR_MAX[AW-1:0];
    end else begin
      dir_clamped = raw_angle[AW-1:0];
    end
    // Spans may be negative when a limit sits on the wrong side of the centre.
    if (dir_clamped[AW-1]) begin
      span = signed'({1'b0, center_angle}) - signed'({1'b0, left_limit});
    end else begin
      span = signed'({1'b0, right_limit}) - signed'({1'b0, center_angle});
    end
    num_full = dir_clamped * span;
  end

  logic                                mode1;
  logic signed [sst_pkg::PROD_W-1:0]   num1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1 <= s_axis_tuser;
      num1  <= num_full[sst_pkg::PROD_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: divide the magnitude by 900, rounding half away from zero.
  // -------------------------------------------------------------------------
  logic [sst_pkg::PROD_W-1:0]                 num_neg;
  logic [sst_pkg::MAG_W-1:0]                  mag;
  logic [sst_pkg::MAG_W-1:0]                  mag_rnd;
  logic [sst_pkg::Y_W+sst_pkg::RECIP_W-1:0]   quot_prod;

  always_comb begin
    num_neg   = -num1;
    mag       = num1[sst_pkg::PROD_W-1] ? num_neg[sst_pkg::MAG_W-1:0]
                                        : num1[sst_pkg::MAG_W-1:0];
    mag_rnd   = mag + sst_pkg::ROUND_HALF;
    quot_prod = mag_rnd[sst_pkg::MAG_W-1:2] * sst_pkg::RECIP_K;
  end

  logic           mode2;
  logic           neg2;
  logic [AW-1:0]  quot2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2 <= mode1;
      neg2  <= num1[sst_pkg::PROD_W-1];
      quot2 <= quot_prod[sst_pkg::RECIP_SHIFT +: AW];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: offset from the centre, then clamp to the right limit and then
  // the left limit, so crossed limits settle on the left one.
  // -------------------------------------------------------------------------
  logic signed [AW+1:0]  offset;
  logic signed [AW+1:0]  mapped;
  logic [AW-1:0]         mapped_clamped;

  always_comb begin
    offset = neg2 ? -signed'({2'b00, quot2}) : signed'({2'b00, quot2});
    mapped = signed'({2'b00, center_angle}) + offset;
    if (mapped > signed'({2'b00, right_limit})) begin
      mapped = signed'({2'b00, right_limit});
    end
    if (mapped < signed'({2'b00, left_limit})) begin
      mapped = signed'({2'b00, left_limit});
    end
    mapped_clamped = mapped[AW-1:0];
  end

  logic           mode3;
  logic [AW-1:0]  target3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mode3   <= mode2;
      target3 <= mapped_clamped;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: tracking state. Ticks count up and saturate; a direction beat
  // replaces the target. A command goes out once the interval has passed and
  // the target is at least the deadband away, moving by at most max_step.
  // -------------------------------------------------------------------------
  logic [AW-1:0]               goal_angle;
  logic                        has_target;
  logic [AW-1:0]               current_angle;
  logic [TICK_COUNT_BITS-1:0]  ticks_since_command;

  logic [AW-1:0]               target_next;
  logic                        has_target_next;
  logic [TICK_COUNT_BITS-1:0]  ticks_next;
  logic                        move_up;
  logic [AW-1:0]               diff;
  logic [AW-1:0]               step;
  logic [AW-1:0]               angle_next;
  logic                        fire;

  always_comb begin
    target_next     = mode3 ? goal_angle : target3;
    has_target_next = has_target || !mode3;
    ticks_next      = ticks_since_command;
    if (mode3 && (ticks_since_command != {TICK_COUNT_BITS{1'b1}})) begin
      ticks_next = ticks_since_command + TICK_COUNT_BITS'(1);
    end
    move_up    = target_next >= current_angle;
    diff       = move_up ? (target_next - current_angle) : (current_angle - target_next);
    step       = (diff < max_step) ? diff : max_step;
    angle_next = move_up ? (current_angle + step) : (current_angle - step);
    fire       = has_target_next
              && (CMP_W'(ticks_next) >= CMP_W'(min_interval))
              && (diff >= deadband);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_angle          <= '0;
      has_target          <= 1'b0;
      current_angle       <= sst_pkg::CURRENT_RST;
      ticks_since_command <= '0;
    end else if (go4) begin
      goal_angle          <= target_next;
      has_target          <= has_target_next;
      if (fire) begin
        current_angle       <= angle_next;
        ticks_since_command <= '0;
      end else begin
        ticks_since_command <= ticks_next;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic [AW-1:0]  out_angle;
  logic           out_reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (go4 && fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go4 && fire) begin
      out_angle   <= angle_next;
      out_reached <= (angle_next == target_next);
    end
  end

  assign m_axis_tdata = {{(sst_pkg::M_TDATA_W-AW-1){1'b0}}, out_reached, out_angle};

endmodule

`default_nettype wire
